// ----- sv/pbd_pkg.sv -----
// Shared types, constants and result codes for the PackBits block decoder.
// No dependencies; every other file of the decoder refers to this package.
package pbd_pkg;

  localparam int BLOCK_BYTES_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int WORD_BYTES      = 8;

  localparam logic [7:0] CTRL_RESERVED = 8'd128;
  localparam logic [8:0] REP_BASE      = 9'd257;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_CODE128   = 3'd1;
  localparam logic [2:0] ERR_OVER_RAW  = 3'd2;
  localparam logic [2:0] ERR_LIT_TRUNC = 3'd3;
  localparam logic [2:0] ERR_NO_REPEAT = 3'd4;
  localparam logic [2:0] ERR_SHORT     = 3'd5;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [11:0] encoded_length;
    logic [11:0] raw_length;
  } in_t;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic        block_done;
    logic [2:0]  error_code;
  } out_t;

  // One queued job: emit len copies of value (len 0 gives an empty result).
  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic       done;
    logic [2:0] err;
  } job_t;

endpackage

// ----- sv/pbd_front.sv -----
// Front end of the PackBits block decoder: parses control bytes, tracks block state.
// Emits one job per encoded byte that yields results. Depends on pbd_pkg.
module pbd_front #(
  parameter int BLOCK_BYTES = pbd_pkg::BLOCK_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  pbd_pkg::in_t  in_i,
  output logic          push_o,
  output pbd_pkg::job_t job_o
);

  localparam int LW = $clog2(BLOCK_BYTES + 1);

  localparam logic [1:0] PH_CTRL = 2'd0;
  localparam logic [1:0] PH_LIT  = 2'd1;
  localparam logic [1:0] PH_REP  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  logic [1:0]    phase_q, phase_d;
  logic [7:0]    lit_left_q, lit_left_d;
  logic [7:0]    rep_cnt_q, rep_cnt_d;
  logic [LW-1:0] pos_q, pos_d;
  logic [LW-1:0] dec_q, dec_d;
  logic [LW-1:0] enc_len_q, enc_len_d;
  logic [LW-1:0] raw_len_q, raw_len_d;

  logic [LW-1:0] enc_len, raw_len, pos_n;
  logic [8:0]    n_w;
  logic [7:0]    n;
  logic [7:0]    b;
  logic [2:0]    err;
  logic          done;
  logic          has_data;
  logic [7:0]    data_len;

  function automatic logic [LW-1:0] clamp_len(input logic [11:0] v);
    logic [LW-1:0] r;
    if (v == 12'd0) begin
      r = LW'(1);
    end else if (32'(v) > 32'(BLOCK_BYTES)) begin
      r = LW'(BLOCK_BYTES);
    end else begin
      r = LW'(v);
    end
    return r;
  endfunction

  assign b = in_i.data_byte;
  assign n_w = (b < pbd_pkg::CTRL_RESERVED) ? ({1'b0, b} + 9'd1)
                                            : (pbd_pkg::REP_BASE - {1'b0, b});
  assign n = n_w[7:0];

  always_comb begin
    phase_d    = phase_q;
    lit_left_d = lit_left_q;
    rep_cnt_d  = rep_cnt_q;
    pos_d      = pos_q;
    dec_d      = dec_q;
    enc_len_d  = enc_len_q;
    raw_len_d  = raw_len_q;
    err        = pbd_pkg::ERR_NONE;
    done       = 1'b0;
    has_data   = 1'b0;
    data_len   = 8'd0;
    push_o     = 1'b0;
    job_o      = '0;

    enc_len = enc_len_q;
    raw_len = raw_len_q;
    if (phase_q == PH_CTRL && pos_q == '0) begin
      enc_len = clamp_len(in_i.encoded_length);
      raw_len = clamp_len(in_i.raw_length);
    end
    pos_n = pos_q + LW'(1);

    if (accept_i && phase_q == PH_SKIP) begin
      // Drop the rest of a failed block without results.
      pos_d = pos_n;
      if (pos_n >= enc_len_q) begin
        phase_d   = PH_CTRL;
        pos_d     = '0;
        dec_d     = '0;
        enc_len_d = '0;
        raw_len_d = '0;
      end
    end else if (accept_i) begin
      enc_len_d = enc_len;
      raw_len_d = raw_len;
      pos_d     = pos_n;
      unique case (phase_q)
        PH_CTRL: begin
          if (b == pbd_pkg::CTRL_RESERVED) begin
            err = pbd_pkg::ERR_CODE128;
          end else if (({1'b0, dec_q} + (LW + 1)'(n)) > {1'b0, raw_len}) begin
            err = pbd_pkg::ERR_OVER_RAW;
          end else if (b < pbd_pkg::CTRL_RESERVED) begin
            if (({1'b0, pos_n} + (LW + 1)'(n)) > {1'b0, enc_len}) begin
              err = pbd_pkg::ERR_LIT_TRUNC;
            end else begin
              lit_left_d = n;
              phase_d    = PH_LIT;
            end
          end else begin
            if (pos_n >= enc_len) begin
              err = pbd_pkg::ERR_NO_REPEAT;
            end else begin
              rep_cnt_d = n;
              phase_d   = PH_REP;
            end
          end
        end
        PH_LIT: begin
          has_data = 1'b1;
          data_len = 8'd1;
          dec_d    = dec_q + LW'(1);
          if (lit_left_q != 8'd0) begin
            lit_left_d = lit_left_q - 8'd1;
          end
          if (lit_left_d == 8'd0) begin
            phase_d = PH_CTRL;
          end
        end
        PH_REP: begin
          has_data  = 1'b1;
          data_len  = rep_cnt_q;
          dec_d     = dec_q + LW'(rep_cnt_q);
          rep_cnt_d = 8'd0;
          phase_d   = PH_CTRL;
        end
        default: begin
        end
      endcase

      done = (err != pbd_pkg::ERR_NONE) || (phase_d == PH_CTRL && pos_n >= enc_len);
      if (done && err == pbd_pkg::ERR_NONE && dec_d != raw_len) begin
        err = pbd_pkg::ERR_SHORT;
      end

      push_o      = has_data || done;
      job_o.value = has_data ? b : 8'd0;
      job_o.len   = data_len;
      job_o.done  = done;
      job_o.err   = err;

      if (done) begin
        lit_left_d = 8'd0;
        rep_cnt_d  = 8'd0;
        if (err != pbd_pkg::ERR_NONE && pos_n < enc_len) begin
          phase_d = PH_SKIP;
        end else begin
          phase_d   = PH_CTRL;
          pos_d     = '0;
          dec_d     = '0;
          enc_len_d = '0;
          raw_len_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CTRL;
      lit_left_q <= '0;
      rep_cnt_q  <= '0;
      pos_q      <= '0;
      dec_q      <= '0;
      enc_len_q  <= '0;
      raw_len_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      rep_cnt_q  <= rep_cnt_d;
      pos_q      <= pos_d;
      dec_q      <= dec_d;
      enc_len_q  <= enc_len_d;
      raw_len_q  <= raw_len_d;
    end
  end

endmodule

// ----- sv/pbd_queue.sv -----
// Short job queue between the front end and the word generator of the decoder.
// Depends on pbd_pkg for the job type.
module pbd_queue #(
  parameter int DEPTH = pbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pbd_pkg::job_t job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output pbd_pkg::job_t head_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pbd_pkg::job_t entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (!push_i && pop_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- sv/pbd_back.sv -----
// Back end of the decoder: expands queued jobs into result words and holds the output register.
// Depends on pbd_pkg for the job and result types.
module pbd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  pbd_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pbd_pkg::out_t out_data_o
);

  logic [3:0]    idx_q;
  logic [7:0]    rem;
  logic          last;
  logic [3:0]    cnt;
  logic [63:0]   word;
  logic          load;
  logic          out_valid_q;
  pbd_pkg::out_t out_q;

  assign rem  = head_i.len - {1'b0, idx_q, 3'b000};
  assign last = (rem <= 8'(pbd_pkg::WORD_BYTES));
  assign cnt  = last ? rem[3:0] : 4'(pbd_pkg::WORD_BYTES);

  always_comb begin
    for (int i = 0; i < pbd_pkg::WORD_BYTES; i++) begin
      word[8*i +: 8] = (4'(i) < cnt) ? head_i.value : 8'd0;
    end
  end

  assign load  = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = load && last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.data_word   <= word;
      out_q.byte_count  <= cnt;
      out_q.last_of_run <= last;
      out_q.block_done  <= last && head_i.done;
      out_q.error_code  <= last ? head_i.err : pbd_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= last ? 4'd0 : idx_q + 4'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/packbits_block_decoder.sv -----
// Top level of the PackBits block decoder: front end, job queue and word generator.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
//
// Usage: the input channel carries one encoded byte per transaction, together
// with the block's encoded and decoded lengths, which are sampled only on the
// first byte of each block. The output channel carries decoded results: a
// literal byte gives one single-byte result, a repeat run gives up to sixteen
// 8-byte words, and a block end or error gives a flag on the last result.
// Both channels use valid/stall; a transaction completes when valid is high
// and stall is low.
// Throughput: one encoded byte per cycle while results keep up. The limit is
// the word generator, which emits one result per cycle when not stalled, so
// a repeat of n bytes occupies it for ceil(n/8) results and the input stalls
// once the job queue fills behind it.
// With the queue empty, the job for an input byte is written into the queue at
// the edge that accepts the byte; the output register then takes its result.
// Reset clears the block state, empties the queue and drops any pending
// result; the next byte starts a new block. When the receiver stalls, the
// output register holds its result, the queue absorbs a few more jobs and
// then the input channel stalls in turn.
module packbits_block_decoder #(
  parameter int BLOCK_BYTES = pbd_pkg::BLOCK_BYTES_DEF,
  parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pbd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pbd_pkg::out_t out_data_o
);

  logic          q_full;
  logic          q_valid;
  logic          q_push;
  logic          q_pop;
  logic          accept;
  pbd_pkg::job_t push_job;
  pbd_pkg::job_t head_job;

  // A byte is taken whenever the queue has room, even if it yields no job.
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  pbd_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .in_i    (in_data_i),
    .push_o  (q_push),
    .job_o   (push_job)
  );

  pbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (head_job)
  );

  pbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (head_job),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The front end only produces jobs for accepted bytes, so never into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> !q_push)
    else $error("job pushed into a full queue");

  // A job is retired only when one is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  // Errors and block ends ride only on a job's final result, with block_done set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (out_data_o.error_code != pbd_pkg::ERR_NONE || out_data_o.block_done)
      |-> out_data_o.last_of_run && out_data_o.block_done)
    else $error("error or block end flagged off the final result");

  // A result never claims more bytes than a word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> out_data_o.byte_count <= 4'(pbd_pkg::WORD_BYTES))
    else $error("result byte count exceeds the word size");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for packbits_block_decoder: directed rows, then random blocks.
// Depends on pbd_pkg and the decoder RTL; it carries its own PackBits decode predictor.
`timescale 1ns / 100ps

module testbench;

  // Encoded bytes fed over the whole run, directed rows included.
  localparam int unsigned TOTAL_ITEMS = 210;
  // The receiver hold-off used to back the job queue up into the input side.
  localparam int unsigned HOLD_CYCLES = 120;
  // Cycles of quiet output after the last expected result has arrived.
  localparam int unsigned TAIL_CYCLES = 40;
  // Watchdog limit for the whole run.
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef enum logic [1:0] {AWAIT_CTRL, IN_LITERAL, IN_REPEAT, SKIPPING} decode_phase_e;

  // How a directed row is checked: by the predictor, or by a result typed in
  // below (either no result at all or exactly one).
  typedef enum logic [1:0] {CHECK_MODEL, EXPECT_NONE, EXPECT_ONE} row_check_e;

  typedef struct {
    pbd_pkg::in_t  item;
    row_check_e    how;
    pbd_pkg::out_t result;
  } stim_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  pbd_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  pbd_pkg::out_t out_data_o;

  packbits_block_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Predictor state: the decoder's view of the block in progress.
  decode_phase_e dec_phase;
  int unsigned   lit_left;
  int unsigned   rep_len;
  int unsigned   enc_pos;
  int unsigned   dec_total;
  int unsigned   blk_enc_len;
  int unsigned   blk_raw_len;

  pbd_pkg::out_t fresh_results[$];    // results caused by the byte just decoded
  pbd_pkg::out_t awaited_results[$];  // results the decoder still owes, oldest first
  stim_row_t     directed_rows[$];

  int unsigned cycle_count = 0;
  int unsigned bytes_fed = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned block_ends[6];
  bit          gapless = 1'b0;
  bit          hold_request = 1'b0;

  // Clock: 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // The watchdog ends a run that stops making progress.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results still owed.",
             cycle_count, awaited_results.size());
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Both lengths are clamped to 1..BLOCK_BYTES when a block opens.
  function automatic int unsigned clamp_length(logic [11:0] v);
    if (v == 12'd0) return 1;
    if (int'(v) > pbd_pkg::BLOCK_BYTES_DEF) return pbd_pkg::BLOCK_BYTES_DEF;
    return int'(v);
  endfunction

  function automatic void open_block();
    dec_phase   = AWAIT_CTRL;
    lit_left    = 0;
    rep_len     = 0;
    enc_pos     = 0;
    dec_total   = 0;
    blk_enc_len = 0;
    blk_raw_len = 0;
  endfunction

  // A result word holding cnt copies of v from the low byte up, upper bytes zero.
  function automatic pbd_pkg::out_t run_word(logic [7:0] v, int unsigned cnt);
    pbd_pkg::out_t r;
    r = '0;
    for (int k = 0; k < int'(cnt); k++) r.data_word[8*k +: 8] = v;
    r.byte_count = 4'(cnt);
    return r;
  endfunction

  // Works out the results of one accepted encoded byte into fresh_results and
  // advances the predicted block state.
  task automatic decode_byte(input pbd_pkg::in_t it);
    logic [2:0]    err;
    bit            done;
    int unsigned   n;
    int unsigned   left;
    int unsigned   c;
    pbd_pkg::out_t res;
    begin
      fresh_results.delete();
      err  = pbd_pkg::ERR_NONE;
      done = 1'b0;

      // After an error the rest of the block is swallowed without results.
      if (dec_phase == SKIPPING) begin
        enc_pos++;
        if (enc_pos >= blk_enc_len) open_block();
        return;
      end

      // The lengths travel with every byte but only the opening one counts.
      if (dec_phase == AWAIT_CTRL && enc_pos == 0) begin
        blk_enc_len = clamp_length(it.encoded_length);
        blk_raw_len = clamp_length(it.raw_length);
      end
      enc_pos++;

      case (dec_phase)
        AWAIT_CTRL: begin
          if (it.data_byte == pbd_pkg::CTRL_RESERVED) begin
            err = pbd_pkg::ERR_CODE128;
          end else begin
            if (it.data_byte < pbd_pkg::CTRL_RESERVED) n = int'(it.data_byte) + 1;
            else n = int'(pbd_pkg::REP_BASE) - int'(it.data_byte);
            if (dec_total + n > blk_raw_len) begin
              err = pbd_pkg::ERR_OVER_RAW;
            end else if (it.data_byte < pbd_pkg::CTRL_RESERVED) begin
              // A literal run must fit entirely inside the encoded block.
              if (enc_pos + n > blk_enc_len) begin
                err = pbd_pkg::ERR_LIT_TRUNC;
              end else begin
                lit_left  = n;
                dec_phase = IN_LITERAL;
              end
            end else begin
              // A repeat needs one more byte for its value.
              if (enc_pos >= blk_enc_len) begin
                err = pbd_pkg::ERR_NO_REPEAT;
              end else begin
                rep_len   = n;
                dec_phase = IN_REPEAT;
              end
            end
          end
        end
        IN_LITERAL: begin
          fresh_results.push_back(run_word(it.data_byte, 1));
          dec_total++;
          if (lit_left > 0) lit_left--;
          if (lit_left == 0) dec_phase = AWAIT_CTRL;
        end
        default: begin
          // Repeat value: full 8-byte words, then one partial word if needed.
          left = rep_len;
          while (left > 0 && fresh_results.size() < 16) begin
            c = (left > pbd_pkg::WORD_BYTES) ? pbd_pkg::WORD_BYTES : left;
            fresh_results.push_back(run_word(it.data_byte, c));
            left -= c;
          end
          dec_total += rep_len;
          rep_len   = 0;
          dec_phase = AWAIT_CTRL;
        end
      endcase

      // A block that reaches its encoded end on a run boundary is finished;
      // its decoded total must then match the announced raw length.
      if (err == pbd_pkg::ERR_NONE && dec_phase == AWAIT_CTRL && enc_pos >= blk_enc_len) begin
        done = 1'b1;
        if (dec_total != blk_raw_len) err = pbd_pkg::ERR_SHORT;
      end
      if (err != pbd_pkg::ERR_NONE) done = 1'b1;
      if (done && fresh_results.size() == 0) fresh_results.push_back(run_word(8'd0, 0));
      if (fresh_results.size() == 0) return;

      res = fresh_results.pop_back();
      res.last_of_run = 1'b1;
      if (done) begin
        res.block_done = 1'b1;
        res.error_code = err;
        if (err != pbd_pkg::ERR_NONE && enc_pos < blk_enc_len) begin
          dec_phase = SKIPPING;
          lit_left  = 0;
          rep_len   = 0;
        end else begin
          open_block();
        end
      end
      fresh_results.push_back(res);
    end
  endtask

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------

  // Offers one encoded byte, holds it through any stall, and records what the
  // decoder owes for it once the transaction completes. Entered and left just
  // after a falling edge; valid stays high from one byte to the next unless a
  // gap is inserted.
  task automatic send_item(input pbd_pkg::in_t it, input row_check_e how,
                           input pbd_pkg::out_t typed_res);
    int unsigned gap;
    int unsigned r;
    begin
      gap = 0;
      if (!gapless) begin
        r = $urandom_range(0, 99);
        if (r >= 96) gap = $urandom_range(12, 40);
        else if (r >= 70) gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      in_data_i  = it;
      in_valid_i = 1'b1;
      // Stall is read at the rising edge, before the decoder's registers move.
      do @(posedge clk_i); while (in_stall_o !== 1'b0);
      bytes_fed++;
      decode_byte(it);
      case (how)
        CHECK_MODEL: foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
        EXPECT_ONE:  awaited_results.push_back(typed_res);
        default:     ;
      endcase
      @(negedge clk_i);
    end
  endtask

  // The sender pauses until the decoder has delivered everything it owes.
  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  // Builds and sends one random block. Most blocks are well formed: a mix of
  // literal and repeat runs whose announced lengths match exactly. The rest
  // are bent into each error: a raw length that is too small or too large, a
  // reserved control byte in place of a real one, an encoded length that cuts
  // the block short, or plain noise. A heavy block is eight maximal repeats.
  task automatic send_block(input bit heavy);
    logic [7:0]   coded[$];
    int unsigned  ctrl_at[$];
    int unsigned  total;
    int unsigned  n;
    int unsigned  runs;
    int unsigned  cut;
    int unsigned  r;
    logic [11:0]  enc_f;
    logic [11:0]  raw_f;
    pbd_pkg::in_t it;
    begin
      total = 0;
      runs  = heavy ? 8 : $urandom_range(1, 6);
      for (int k = 0; k < int'(runs); k++) begin
        ctrl_at.push_back(coded.size());
        if (!heavy && $urandom_range(0, 1) == 0) begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
          coded.push_back(8'(n - 1));
          repeat (n) coded.push_back(8'($urandom));
        end else begin
          if (heavy) n = 128;
          else if ($urandom_range(0, 3) == 0) n = $urandom_range(2, 128);
          else n = $urandom_range(2, 24);
          coded.push_back(8'(pbd_pkg::REP_BASE - 9'(n)));
          coded.push_back(8'($urandom));
        end
        total += n;
      end
      enc_f = 12'(coded.size());
      raw_f = 12'(total);

      r = heavy ? 0 : $urandom_range(0, 99);
      if (r >= 65 && r < 72 && total > 1) begin
        raw_f = 12'($urandom_range(1, total - 1));
      end else if (r >= 72 && r < 79) begin
        raw_f = 12'(total + $urandom_range(1, 300));
      end else if (r >= 79 && r < 86) begin
        coded[ctrl_at[$urandom_range(0, ctrl_at.size() - 1)]] = pbd_pkg::CTRL_RESERVED;
      end else if (r >= 86 && r < 93 && coded.size() > 1) begin
        cut = $urandom_range(1, coded.size() - 1);
        while (coded.size() > cut) void'(coded.pop_back());
        enc_f = 12'(cut);
      end else if (r >= 93) begin
        coded.delete();
        repeat ($urandom_range(1, 8)) coded.push_back(8'($urandom));
        enc_f = 12'(coded.size());
        raw_f = 12'($urandom_range(1, 64));
      end

      gapless = heavy || ($urandom_range(0, 2) == 0);
      foreach (coded[i]) begin
        it.data_byte      = coded[i];
        it.encoded_length = (i == 0) ? enc_f : 12'($urandom);
        it.raw_length     = (i == 0) ? raw_f : 12'($urandom);
        send_item(it, CHECK_MODEL, '0);
      end
      gapless = 1'b0;
    end
  endtask

  function automatic void add_row(logic [7:0] b, logic [11:0] enc, logic [11:0] raw,
                                  row_check_e how, pbd_pkg::out_t res);
    stim_row_t row;
    row.item.data_byte      = b;
    row.item.encoded_length = enc;
    row.item.raw_length     = raw;
    row.how                 = how;
    row.result              = res;
    directed_rows.push_back(row);
  endfunction

  // A single result that closes out its input byte.
  function automatic pbd_pkg::out_t sole_result(logic [63:0] word, logic [3:0] cnt,
                                                logic done, logic [2:0] err);
    pbd_pkg::out_t r;
    r.data_word   = word;
    r.byte_count  = cnt;
    r.last_of_run = 1'b1;
    r.block_done  = done;
    r.error_code  = err;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Output side
  // -------------------------------------------------------------------------

  // Receiver stalls: free stretches, short stalls and now and then a long one.
  // A hold request from the sender forces one very long hold-off, counted here.
  initial begin : result_backpressure
    int unsigned r;
    int unsigned span;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_stall_i = 1'b0;
          span = $urandom_range(1, 20);
        end else if (r < 92) begin
          out_stall_i = 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall_i = 1'b1;
          span = $urandom_range(10, 40);
        end
        repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Every completed output transaction is matched against the oldest owed result.
  always @(posedge clk_i) begin : result_monitor
    pbd_pkg::out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = awaited_results.pop_front();
        check_field("data_word", want.data_word, out_data_o.data_word);
        check_field("byte_count", 64'(want.byte_count), 64'(out_data_o.byte_count));
        check_field("last_of_run", 64'(want.last_of_run), 64'(out_data_o.last_of_run));
        check_field("block_done", 64'(want.block_done), 64'(out_data_o.block_done));
        check_field("error_code", 64'(want.error_code), 64'(out_data_o.error_code));
        if (want.block_done) block_ends[want.error_code]++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sequence of the run
  // -------------------------------------------------------------------------

  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    foreach (block_ends[i]) block_ends[i] = 0;
    open_block();
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows. Lengths on bytes other than a block's first are junk that
    // the decoder must ignore.
    // Reserved control byte as a one-byte block.
    add_row(8'h80, 12'd1, 12'd1, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_CODE128));
    // Zero lengths count as one; a one-byte literal has no room for its data.
    add_row(8'h00, 12'd0, 12'd0, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_LIT_TRUNC));
    // Repeat control as the block's last byte, largest raw length field.
    add_row(8'hFF, 12'd1, 12'hFFF, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_NO_REPEAT));
    // Longest repeat against a raw length of one, then the skipped rest.
    add_row(8'h81, 12'd2, 12'd1, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_OVER_RAW));
    add_row(8'hAB, 12'hFFF, 12'hFFF, EXPECT_NONE, '0);
    // Clean block: 128 copies of 0xFF, then the literal bytes 0x00 and 0xFF.
    add_row(8'h81, 12'd5, 12'd130, CHECK_MODEL, '0);
    add_row(8'hFF, 12'h000, 12'h000, CHECK_MODEL, '0);
    add_row(8'h01, 12'h5A5, 12'hA5A, CHECK_MODEL, '0);
    add_row(8'h00, 12'hFFF, 12'h000, CHECK_MODEL, '0);
    add_row(8'hFF, 12'h000, 12'hFFF, CHECK_MODEL, '0);
    // Block that decodes fewer bytes than it announced.
    add_row(8'hFF, 12'd2, 12'd2048, CHECK_MODEL, '0);
    add_row(8'h5A, 12'h123, 12'h456, EXPECT_ONE,
            sole_result(64'h5A5A, 4'd2, 1'b1, pbd_pkg::ERR_SHORT));
    // Reserved control byte in mid-block, then the skipped remainder.
    add_row(8'h00, 12'd4, 12'd10, CHECK_MODEL, '0);
    add_row(8'h7F, 12'h800, 12'h001, CHECK_MODEL, '0);
    add_row(8'h80, 12'h7FF, 12'hFFE, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_CODE128));
    add_row(8'h12, 12'hFFF, 12'hFFF, EXPECT_NONE, '0);
    // Literal that runs past the encoded end, with two skipped bytes after it.
    add_row(8'h02, 12'd3, 12'd20, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_LIT_TRUNC));
    add_row(8'h55, 12'h000, 12'h000, EXPECT_NONE, '0);
    add_row(8'hAA, 12'hFFF, 12'hFFF, EXPECT_NONE, '0);
    // Repeats of exactly one word and of one word plus a byte.
    add_row(8'hF9, 12'd4, 12'd17, CHECK_MODEL, '0);
    add_row(8'h3C, 12'h3C3, 12'hC3C, CHECK_MODEL, '0);
    add_row(8'hF8, 12'h000, 12'h000, CHECK_MODEL, '0);
    add_row(8'hC3, 12'hFFF, 12'hFFF, CHECK_MODEL, '0);
    // Longest literal in a one-byte block.
    add_row(8'h7F, 12'd1, 12'd128, EXPECT_ONE,
            sole_result('0, 4'd0, 1'b1, pbd_pkg::ERR_LIT_TRUNC));

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].how, directed_rows[i].result);
    drain();

    // The receiver holds off for a long stretch while the sender keeps pushing
    // maximal repeats, so the job queue fills and the input channel stalls.
    hold_request = 1'b1;
    send_block(1'b1);
    drain();

    // Random blocks, with the occasional pause until every result is in.
    while (bytes_fed < TOTAL_ITEMS) begin
      send_block(1'b0);
      if ($urandom_range(0, 11) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Fed %0d encoded bytes and checked %0d decoded results in %0d cycles.",
             bytes_fed, results_checked, cycle_count);
    $display("%s %0d, control 128 %0d, over raw %0d, literal cut %0d, %s %0d, short %0d",
             "Block endings: clean", block_ends[pbd_pkg::ERR_NONE],
             block_ends[pbd_pkg::ERR_CODE128], block_ends[pbd_pkg::ERR_OVER_RAW],
             block_ends[pbd_pkg::ERR_LIT_TRUNC], "no repeat value",
             block_ends[pbd_pkg::ERR_NO_REPEAT], block_ends[pbd_pkg::ERR_SHORT]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
